[hw/rtl/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared types and constants of the mecanum wheel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

    // Velocity field width default
    localparam int VELOCITY_BITS_DEF = 10;

    // Duty full scale
    localparam int DUTY_MAX  = 255;
    localparam int DUTY_BITS = 8;

    // Wheels, in output order: front left, front right, back left, back right
    localparam int NUM_WHEELS = 4;
    localparam int WHL_FL     = 0;
    localparam int WHL_FR     = 1;
    localparam int WHL_BL     = 2;
    localparam int WHL_BR     = 3;

    // Rescale divider: quotient bits and bits retired per pipeline stage
    localparam int QUO_BITS       = 8;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;

    // Mode codes; code three behaves as stop
    localparam logic [1:0] MODE_DRIVE = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    // Bridge direction codes
    typedef enum logic [1:0] {
        DIR_COAST = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2,
        DIR_BRAKE = 2'd3
    } t_dir;

endpackage

`default_nettype wire

[hw/rtl/mecanum_wheel_mixer_core.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_core
// Mecanum inverse kinematics: velocity command to four wheel direction/duty.
// ----------------------------------------------------------------------------
// One item (mode plus x, y and rotation velocity) is taken at every rising
// edge where start is high; busy never rises, so an item may enter on every
// cycle. The result for an item is driven on the o_ ports for exactly one
// cycle, marked by o_valid, in item order: o_valid rises once the item has
// passed all seven register stages, and the receiver takes the result while
// o_valid is high.
// There is no back-pressure from the receiver: it must take o_valid whenever
// it shows. In the pipeline, one stage forms the wheel sums and magnitudes,
// one finds the largest magnitude and the scaled numerators, four stages
// run the rescale division (two quotient bits per stage, one divider per
// wheel), and one stage formats the outputs.
// Drive mode: fl=x+y+r, fr=x-y-r, bl=x-y+r, br=x+y-r. When the largest
// magnitude exceeds 255, each wheel gets trunc(|w|*255/max) with the sign of
// w; otherwise |w| is used as is. Stop (and the unused mode code three)
// coasts all wheels at duty 0; brake drives both bridge inputs high at
// the given brake duty.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_mixer_core #(
    parameter int VELOCITY_BITS = mwm_pkg::VELOCITY_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_mode,
    input  wire logic signed [VELOCITY_BITS-1:0] i_vel_x,
    input  wire logic signed [VELOCITY_BITS-1:0] i_vel_y,
    input  wire logic signed [VELOCITY_BITS-1:0] i_vel_rot,
    input  wire logic [7:0]                      i_brake_duty,

    output logic                                 o_valid,
    output logic [1:0]                           o_front_left_dir,
    output logic [7:0]                           o_front_left_duty,
    output logic [1:0]                           o_front_right_dir,
    output logic [7:0]                           o_front_right_duty,
    output logic [1:0]                           o_back_left_dir,
    output logic [7:0]                           o_back_left_duty,
    output logic [1:0]                           o_back_right_dir,
    output logic [7:0]                           o_back_right_duty
);

    // Widths: sums need two extra bits, magnitudes one, numerator adds 8
    localparam int SW  = VELOCITY_BITS + 2;
    localparam int MW  = VELOCITY_BITS + 1;
    localparam int NW  = MW + mwm_pkg::DUTY_BITS;
    localparam int NWH = mwm_pkg::NUM_WHEELS;
    localparam int DS  = mwm_pkg::DIV_STAGES;
    localparam int QB  = mwm_pkg::QUO_BITS;
    localparam int BPS = mwm_pkg::BITS_PER_STAGE;

    // ---------------- stage 1: wheel sums, sign and magnitude ----------------
    logic signed [SW-1:0] x_ext, y_ext, r_ext;
    logic signed [SW-1:0] sum [NWH];
    logic [MW-1:0]        n_s1_mag [NWH];
    logic                 n_s1_neg [NWH];

    logic                 r_s1_valid;
    logic [1:0]           r_s1_mode;
    logic [7:0]           r_s1_brake;
    logic [MW-1:0]        r_s1_mag [NWH];
    logic                 r_s1_neg [NWH];

    always_comb begin
        x_ext = SW'(i_vel_x);
        y_ext = SW'(i_vel_y);
        r_ext = SW'(i_vel_rot);
        sum[mwm_pkg::WHL_FL] = x_ext + y_ext + r_ext;
        sum[mwm_pkg::WHL_FR] = x_ext - y_ext - r_ext;
        sum[mwm_pkg::WHL_BL] = x_ext - y_ext + r_ext;
        sum[mwm_pkg::WHL_BR] = x_ext + y_ext - r_ext;
        for (int w = 0; w < NWH; w++) begin
            n_s1_neg[w] = sum[w][SW-1];
            n_s1_mag[w] = n_s1_neg[w] ? MW'(-sum[w]) : MW'(sum[w]);
        end
    end

    // ---------------- stage 2: max magnitude and numerators ----------------
    // Divider arrays: index 0 is the stage 2 register, index s+1 holds the
    // state after division step s.
    logic [MW-1:0] max_01, max_23, n_max;

    logic          r_dv_valid [DS+1];
    logic [1:0]    r_dv_mode  [DS+1];
    logic [7:0]    r_dv_brake [DS+1];
    logic          r_dv_big   [DS+1];
    logic [MW-1:0] r_dv_max   [DS+1];
    logic [NW-1:0] r_dv_rem   [DS+1][NWH];
    logic [QB-1:0] r_dv_quo   [DS+1][NWH];
    logic          r_dv_neg   [DS+1][NWH];
    logic [7:0]    r_dv_low   [DS+1][NWH];

    always_comb begin
        max_01 = (r_s1_mag[mwm_pkg::WHL_FL] > r_s1_mag[mwm_pkg::WHL_FR])
               ? r_s1_mag[mwm_pkg::WHL_FL] : r_s1_mag[mwm_pkg::WHL_FR];
        max_23 = (r_s1_mag[mwm_pkg::WHL_BL] > r_s1_mag[mwm_pkg::WHL_BR])
               ? r_s1_mag[mwm_pkg::WHL_BL] : r_s1_mag[mwm_pkg::WHL_BR];
        n_max  = (max_01 > max_23) ? max_01 : max_23;
    end

    // ---------------- stages 3..6: restoring division ----------------
    // |w| <= max, so the quotient always fits in eight bits.
    logic [NW-1:0] n_dv_rem [DS][NWH];
    logic [QB-1:0] n_dv_quo [DS][NWH];
    logic [NW-1:0] div_sub;

    always_comb begin
        for (int s = 0; s < DS; s++) begin
            for (int w = 0; w < NWH; w++) begin
                n_dv_rem[s][w] = r_dv_rem[s][w];
                n_dv_quo[s][w] = r_dv_quo[s][w];
                for (int b = 0; b < BPS; b++) begin
                    div_sub = NW'(r_dv_max[s]) << (QB - 1 - s * BPS - b);
                    if (n_dv_rem[s][w] >= div_sub) begin
                        n_dv_rem[s][w] = n_dv_rem[s][w] - div_sub;
                        n_dv_quo[s][w][QB - 1 - s * BPS - b] = 1'b1;
                    end
                end
            end
        end
    end

    // ---------------- stage 7: direction and duty ----------------
    mwm_pkg::t_dir n_out_dir  [NWH];
    logic [7:0]    n_out_duty [NWH];
    logic [7:0]    wheel_val;

    logic          r_out_valid;
    mwm_pkg::t_dir r_out_dir  [NWH];
    logic [7:0]    r_out_duty [NWH];

    always_comb begin
        for (int w = 0; w < NWH; w++) begin
            wheel_val = r_dv_big[DS] ? r_dv_quo[DS][w] : r_dv_low[DS][w];
            if (r_dv_mode[DS] == mwm_pkg::MODE_DRIVE) begin
                n_out_duty[w] = wheel_val;
                if (wheel_val == 8'd0) begin
                    n_out_dir[w] = mwm_pkg::DIR_COAST;
                end else if (r_dv_neg[DS][w]) begin
                    n_out_dir[w] = mwm_pkg::DIR_REV;
                end else begin
                    n_out_dir[w] = mwm_pkg::DIR_FWD;
                end
            end else if (r_dv_mode[DS] == mwm_pkg::MODE_BRAKE) begin
                n_out_dir[w]  = mwm_pkg::DIR_BRAKE;
                n_out_duty[w] = r_dv_brake[DS];
            end else begin
                n_out_dir[w]  = mwm_pkg::DIR_COAST;
                n_out_duty[w] = 8'd0;
            end
        end
    end

    // ---------------- registers ----------------
    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s <= DS; s++) begin
                r_dv_valid[s] <= 1'b0;
            end
        end else begin
            r_s1_valid    <= start & ~busy;
            r_dv_valid[0] <= r_s1_valid;
            for (int s = 0; s < DS; s++) begin
                r_dv_valid[s+1] <= r_dv_valid[s];
            end
            r_out_valid <= r_dv_valid[DS];
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_s1_mode  <= i_mode;
        r_s1_brake <= i_brake_duty;
        for (int w = 0; w < NWH; w++) begin
            r_s1_mag[w] <= n_s1_mag[w];
            r_s1_neg[w] <= n_s1_neg[w];
        end

        r_dv_mode[0]  <= r_s1_mode;
        r_dv_brake[0] <= r_s1_brake;
        r_dv_max[0]   <= n_max;
        r_dv_big[0]   <= (n_max > MW'(mwm_pkg::DUTY_MAX));
        for (int w = 0; w < NWH; w++) begin
            // |w| * 255 = (|w| << 8) - |w|
            r_dv_rem[0][w] <= {r_s1_mag[w], 8'd0} - NW'(r_s1_mag[w]);
            r_dv_quo[0][w] <= '0;
            r_dv_neg[0][w] <= r_s1_neg[w];
            r_dv_low[0][w] <= r_s1_mag[w][7:0];
        end

        for (int s = 0; s < DS; s++) begin
            r_dv_mode[s+1]  <= r_dv_mode[s];
            r_dv_brake[s+1] <= r_dv_brake[s];
            r_dv_max[s+1]   <= r_dv_max[s];
            r_dv_big[s+1]   <= r_dv_big[s];
            for (int w = 0; w < NWH; w++) begin
                r_dv_rem[s+1][w] <= n_dv_rem[s][w];
                r_dv_quo[s+1][w] <= n_dv_quo[s][w];
                r_dv_neg[s+1][w] <= r_dv_neg[s][w];
                r_dv_low[s+1][w] <= r_dv_low[s][w];
            end
        end

        for (int w = 0; w < NWH; w++) begin
            r_out_dir[w]  <= n_out_dir[w];
            r_out_duty[w] <= n_out_duty[w];
        end
    end

    // ---------------- ports ----------------
    // Fully pipelined with no receiver stall: never busy.
    assign busy               = 1'b0;
    assign o_valid            = r_out_valid;
    assign o_front_left_dir   = r_out_dir[mwm_pkg::WHL_FL];
    assign o_front_left_duty  = r_out_duty[mwm_pkg::WHL_FL];
    assign o_front_right_dir  = r_out_dir[mwm_pkg::WHL_FR];
    assign o_front_right_duty = r_out_duty[mwm_pkg::WHL_FR];
    assign o_back_left_dir    = r_out_dir[mwm_pkg::WHL_BL];
    assign o_back_left_duty   = r_out_duty[mwm_pkg::WHL_BL];
    assign o_back_right_dir   = r_out_dir[mwm_pkg::WHL_BR];
    assign o_back_right_duty  = r_out_duty[mwm_pkg::WHL_BR];

endmodule

`default_nettype wire

[verif/mecanum_wheel_mixer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_core_test
// Self-checking bench for the mecanum wheel mixer core.
// ----------------------------------------------------------------------------
// A directed batch of corner commands, then about 1400 random commands, is
// queued up front. A clocked driver launches them on start/busy with random
// idle gaps (and runs with no gaps at all). A clocked monitor takes every
// o_valid strobe and checks the eight wheel fields against a local model of
// the mixer, computed when the command is taken.
// ----------------------------------------------------------------------------

module mecanum_wheel_mixer_core_test;

    localparam int VB = mwm_pkg::VELOCITY_BITS_DEF;

    // Mode code three has no name in the package; the core treats it as stop.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_CMDS  = 1400;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 12;   // pipeline is 7 deep, plus margin

    // One command as driven on the input ports
    typedef struct packed {
        logic [1:0]           mode;
        logic signed [VB-1:0] vx;
        logic signed [VB-1:0] vy;
        logic signed [VB-1:0] vr;
        logic [7:0]           brake;
    } t_mix_cmd;

    // One set of wheel outputs, indexed by WHL_FL .. WHL_BR
    typedef struct packed {
        logic [mwm_pkg::NUM_WHEELS-1:0][1:0] dir;
        logic [mwm_pkg::NUM_WHEELS-1:0][7:0] duty;
    } t_wheel_set;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    logic                 start        = 1'b0;
    logic [1:0]           i_mode       = mwm_pkg::MODE_STOP;
    logic signed [VB-1:0] i_vel_x      = '0;
    logic signed [VB-1:0] i_vel_y      = '0;
    logic signed [VB-1:0] i_vel_rot    = '0;
    logic [7:0]           i_brake_duty = '0;

    logic       busy;
    logic       o_valid;
    logic [1:0] o_front_left_dir,  o_front_right_dir,  o_back_left_dir,  o_back_right_dir;
    logic [7:0] o_front_left_duty, o_front_right_duty, o_back_left_duty, o_back_right_duty;

    mecanum_wheel_mixer_core #(
        .VELOCITY_BITS (VB)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_vel_x            (i_vel_x),
        .i_vel_y            (i_vel_y),
        .i_vel_rot          (i_vel_rot),
        .i_brake_duty       (i_brake_duty),
        .o_valid            (o_valid),
        .o_front_left_dir   (o_front_left_dir),
        .o_front_left_duty  (o_front_left_duty),
        .o_front_right_dir  (o_front_right_dir),
        .o_front_right_duty (o_front_right_duty),
        .o_back_left_dir    (o_back_left_dir),
        .o_back_left_duty   (o_back_left_duty),
        .o_back_right_dir   (o_back_right_dir),
        .o_back_right_duty  (o_back_right_duty)
    );

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_mix_cmd   cmd_backlog[$];       // commands not yet launched
    t_wheel_set wheel_cmds_due[$];    // predicted outputs, oldest first

    int n_errors  = 0;
    int n_checked = 0;
    int mode_taken[4] = '{0, 0, 0, 0};

    string wheel_tag[mwm_pkg::NUM_WHEELS] =
        '{"front_left", "front_right", "back_left", "back_right"};

    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Mixer model: wheel sums, rescale when the peak is above full duty,
    // then sign -> direction and magnitude -> duty.
    // ------------------------------------------------------------------------
    function automatic t_wheel_set mix_wheels(t_mix_cmd c);
        t_wheel_set ws;
        int         sum[mwm_pkg::NUM_WHEELS];
        int         x, y, rot, peak, mag, k;
        ws   = '0;
        x    = $signed(c.vx);
        y    = $signed(c.vy);
        rot  = $signed(c.vr);
        peak = 0;
        case (c.mode)
            mwm_pkg::MODE_DRIVE: begin
                sum[mwm_pkg::WHL_FL] = x + y + rot;
                sum[mwm_pkg::WHL_FR] = x - y - rot;
                sum[mwm_pkg::WHL_BL] = x - y + rot;
                sum[mwm_pkg::WHL_BR] = x + y - rot;
                for (k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
                    mag = (sum[k] < 0) ? -sum[k] : sum[k];
                    if (mag > peak)
                        peak = mag;
                end
                for (k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
                    mag = (sum[k] < 0) ? -sum[k] : sum[k];
                    // truncating rescale; a tiny wheel can drop to zero here
                    if (peak > mwm_pkg::DUTY_MAX)
                        mag = (mag * mwm_pkg::DUTY_MAX) / peak;
                    if (mag == 0) begin
                        ws.dir[k]  = mwm_pkg::DIR_COAST;
                        ws.duty[k] = '0;
                    end else begin
                        ws.dir[k]  = (sum[k] < 0) ? mwm_pkg::DIR_REV : mwm_pkg::DIR_FWD;
                        ws.duty[k] = mag[7:0];
                    end
                end
            end
            mwm_pkg::MODE_BRAKE: begin
                for (k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
                    ws.dir[k]  = mwm_pkg::DIR_BRAKE;
                    ws.duty[k] = c.brake;
                end
            end
            default: begin
                // stop and the spare code: everything coasts at zero duty
                for (k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
                    ws.dir[k]  = mwm_pkg::DIR_COAST;
                    ws.duty[k] = '0;
                end
            end
        endcase
        return ws;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_mix_cmd mk_cmd(logic [1:0] mode, int x, int y, int r, int b);
        t_mix_cmd c;
        c.mode  = mode;
        c.vx    = x[VB-1:0];
        c.vy    = y[VB-1:0];
        c.vr    = r[VB-1:0];
        c.brake = b[7:0];
        return c;
    endfunction

    // style 0: small (never rescaled), 1: full range, 2: corner values
    function automatic logic signed [VB-1:0] draw_vel(int style);
        int corner[11] = '{-512, 511, 0, 1, -1, 255, -255, 256, -256, 85, -85};
        int v;
        case (style)
            0:       v = $urandom_range(0, 170) - 85;
            1:       v = $signed(VB'($urandom));
            default: v = corner[$urandom_range(0, 10)];
        endcase
        return v[VB-1:0];
    endfunction

    function automatic t_mix_cmd random_cmd();
        t_mix_cmd c;
        int       pick, style;
        pick  = $urandom_range(0, 99);
        style = $urandom_range(0, 2);
        if (pick < 70)
            c.mode = mwm_pkg::MODE_DRIVE;
        else if (pick < 80)
            c.mode = mwm_pkg::MODE_STOP;
        else if (pick < 92)
            c.mode = mwm_pkg::MODE_BRAKE;
        else
            c.mode = MODE_SPARE;
        // velocities stay random in every mode; outside drive they must be ignored
        c.vx    = draw_vel(style);
        c.vy    = draw_vel(style);
        c.vr    = draw_vel(style);
        c.brake = 8'($urandom);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: hold start until the item is taken, then idle for the drawn
    // gap. quiet_run switches to back-to-back launches for a while.
    // ------------------------------------------------------------------------
    t_mix_cmd cur_cmd;
    int       gap_left  = 0;
    bit       quiet_run = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            // item on the ports taken at this edge: predict it now
            if (start && !busy) begin
                wheel_cmds_due.push_back(mix_wheels(cur_cmd));
                mode_taken[cur_cmd.mode]++;
            end
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (cmd_backlog.size() != 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    i_mode       <= cur_cmd.mode;
                    i_vel_x      <= cur_cmd.vx;
                    i_vel_y      <= cur_cmd.vy;
                    i_vel_rot    <= cur_cmd.vr;
                    i_brake_duty <= cur_cmd.brake;
                    start        <= 1'b1;
                    if ($urandom_range(0, 47) == 0)
                        quiet_run = !quiet_run;
                    gap_left <= quiet_run ? 0 : $urandom_range(0, 15);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobe is one result; compare field by field.
    // ------------------------------------------------------------------------
    t_wheel_set got_set, want_set;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got_set.dir[mwm_pkg::WHL_FL]  = o_front_left_dir;
            got_set.duty[mwm_pkg::WHL_FL] = o_front_left_duty;
            got_set.dir[mwm_pkg::WHL_FR]  = o_front_right_dir;
            got_set.duty[mwm_pkg::WHL_FR] = o_front_right_duty;
            got_set.dir[mwm_pkg::WHL_BL]  = o_back_left_dir;
            got_set.duty[mwm_pkg::WHL_BL] = o_back_left_duty;
            got_set.dir[mwm_pkg::WHL_BR]  = o_back_right_dir;
            got_set.duty[mwm_pkg::WHL_BR] = o_back_right_duty;
            if (wheel_cmds_due.size() == 0) begin
                report_error("result strobe with no command outstanding");
            end else begin
                want_set = wheel_cmds_due.pop_front();
                n_checked++;
                for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
                    if (got_set.dir[k] !== want_set.dir[k])
                        report_error($sformatf("result %0d %s_dir: expected %0d, got %0d",
                            n_checked, wheel_tag[k], want_set.dir[k], got_set.dir[k]));
                    if (got_set.duty[k] !== want_set.duty[k])
                        report_error($sformatf("result %0d %s_duty: expected %0d, got %0d",
                            n_checked, wheel_tag[k], want_set.duty[k], got_set.duty[k]));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command list and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int n;
        // zero, full-scale corners, and sums right at the rescale threshold
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,    0,    0,    0,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  511,  511,  511,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE, -512, -512, -512, 255));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  511, -512,  511,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE, -512,  511, -512,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  255,    0,    0,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE, -255,    0,    0,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  256,    0,    0,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,    0, -256,    0,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,    0,    0,  300,   0));
        // some wheel sums cancel to zero -> coast inside drive mode
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  100,  100,    0,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,    0,   50,  -50,   0));
        // tiny wheel next to a huge peak rescales down to zero; tiny sums alone stay
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  511,  511,    1,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,    1,   -1,    1,   0));
        // stop, brake and the spare mode code, velocities mostly not zero; then drive
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_STOP,   511, -512,  100, 255));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_BRAKE,  300,  -20,    7,   0));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_BRAKE, -512,  511,    0, 255));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_BRAKE,    0,    0,    0, 165));
        cmd_backlog.push_back(mk_cmd(MODE_SPARE,          -300,  200,  -77,  90));
        cmd_backlog.push_back(mk_cmd(mwm_pkg::MODE_DRIVE,  -40,   30,   20,   0));
        for (n = 0; n < RANDOM_CMDS; n++)
            cmd_backlog.push_back(random_cmd());

        @(posedge i_clk iff i_rst_n);
        while (cmd_backlog.size() != 0 || start)
            @(posedge i_clk);
        while (wheel_cmds_due.size() != 0)
            @(posedge i_clk);
        // any strobe beyond this point is an extra result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (wheel_cmds_due.size() != 0)
            report_error($sformatf("%0d results never arrived", wheel_cmds_due.size()));

        $display("covered %0d commands: drive %0d, stop %0d, brake %0d, spare code %0d",
            mode_taken[0] + mode_taken[1] + mode_taken[2] + mode_taken[3],
            mode_taken[mwm_pkg::MODE_DRIVE], mode_taken[mwm_pkg::MODE_STOP],
            mode_taken[mwm_pkg::MODE_BRAKE], mode_taken[MODE_SPARE]);
        $display("compared %0d wheel results, %0d errors", n_checked, n_errors);
        if (n_errors == 0)
            $display("mecanum_wheel_mixer_core regression: pass");
        else
            $display("mecanum_wheel_mixer_core regression: fail");
        $finish;
    end

    // Hang guard: well past the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout waiting for the core");
        $display("mecanum_wheel_mixer_core regression: fail");
        $finish;
    end

endmodule
